[hdl/i2cms_pkg.sv]
// Package for the I2C master transfer sequencer: beat types, codes and status bit positions.
package i2cms_pkg;

    localparam int LEN_BITS = 16;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_EVENT = 2'd1,
        FUNC_ERROR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_START = 2'd1,
        BUS_STOP  = 2'd2
    } bus_cmd_t;

    typedef enum logic [1:0] {
        ACK_KEEP  = 2'd0,
        ACK_CLEAR = 2'd1,
        ACK_SET   = 2'd2
    } ack_ctl_t;

    typedef enum logic [1:0] {
        POS_KEEP  = 2'd0,
        POS_SET   = 2'd1,
        POS_CLEAR = 2'd2
    } pos_ctl_t;

    // Bit positions in the status snapshot.
    localparam int ST_SB   = 0;
    localparam int ST_ADDR = 1;
    localparam int ST_BTF  = 2;
    localparam int ST_RXNE = 6;
    localparam int ST_TXE  = 7;
    localparam int ST_AF   = 10;

    localparam logic RW_READ = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_SB   = 6'b000010,
        PH_ADDR = 6'b000100,
        PH_DATA = 6'b001000,
        PH_BTF  = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  target_addr;
        logic        is_read;
        logic [15:0] byte_count;
        logic [10:0] status_flags;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_first;
        logic [7:0]  rx_second;
    } req_t;

    typedef struct packed {
        logic        dr_write;
        logic [7:0]  dr_value;
        logic [1:0]  rx_count;
        logic [7:0]  rx_byte_a;
        logic [7:0]  rx_byte_b;
        logic [15:0] rx_index;
        logic [1:0]  bus_command;
        logic [1:0]  ack_control;
        logic [1:0]  pos_control;
        logic        addr_clear;
        logic        done_res;
        logic        failed;
    } rsp_t;

endpackage

[hdl/i2cms_in_reg.sv]
// Input register stage: holds one request beat for the sequencer.
module i2cms_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  i2cms_pkg::req_t req,
    output logic            item_valid,
    output i2cms_pkg::req_t item,
    input  logic            item_take
);
    import i2cms_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t data_reg;

    assign req_ready  = !valid_reg || item_take;
    assign valid_next = (req_valid && req_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            data_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;
endmodule

[hdl/i2cms_seq.sv]
// Transfer state and the single-pass next-state and result logic.
module i2cms_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  i2cms_pkg::req_t item,
    output i2cms_pkg::rsp_t result
);
    import i2cms_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [LEN_BITS-1:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [6:0]          addr_reg, addr_next;
    logic                rd_reg, rd_next;

    logic [LEN_BITS-1:0] pos_inc;
    logic [LEN_BITS:0]   pos_plus;
    logic                len_one;
    logic                len_two;
    logic                len_big;
    logic                pos_in_range;
    logic [10:0]         sr;

    assign sr           = item.status_flags;
    assign pos_inc      = pos_reg + LEN_BITS'(1);
    assign pos_plus     = {1'b0, pos_reg} + (LEN_BITS+1)'(1);
    assign len_one      = (len_reg == LEN_BITS'(1));
    assign len_two      = (len_reg == LEN_BITS'(2));
    assign len_big      = (len_reg >= LEN_BITS'(3));
    assign pos_in_range = (pos_reg < len_reg);

    always_comb
    begin
        result     = '0;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        rd_next    = rd_reg;
        if (fire)
        begin
            unique case (item.func)
                FUNC_START:
                begin
                    addr_next          = item.target_addr;
                    rd_next            = item.is_read;
                    len_next           = LEN_BITS'(item.byte_count);
                    pos_next           = '0;
                    phase_next         = PH_SB;
                    result.bus_command = BUS_START;
                end
                FUNC_EVENT:
                begin
                    if (sr[ST_SB] && phase_reg == PH_SB)
                    begin
                        result.dr_write = 1'b1;
                        result.dr_value = {addr_reg, rd_reg};
                        phase_next      = PH_ADDR;
                    end
                    else if (sr[ST_ADDR] && phase_reg == PH_ADDR)
                    begin
                        result.addr_clear = 1'b1;
                        pos_next          = '0;
                        phase_next        = PH_DATA;
                        if (rd_reg == RW_READ)
                        begin
                            if (len_reg == '0)
                            begin
                                result.bus_command = BUS_STOP;
                                result.done_res    = 1'b1;
                                phase_next         = PH_DONE;
                            end
                            else if (len_one)
                            begin
                                result.ack_control = ACK_CLEAR;
                                result.bus_command = BUS_STOP;
                            end
                            else if (len_two)
                            begin
                                result.pos_control = POS_SET;
                                result.ack_control = ACK_CLEAR;
                                phase_next         = PH_BTF;
                            end
                            else
                            begin
                                result.ack_control = ACK_SET;
                            end
                        end
                    end
                    else if (sr[ST_TXE] && rd_reg != RW_READ && phase_reg == PH_DATA)
                    begin
                        if (pos_in_range)
                        begin
                            result.dr_write = 1'b1;
                            result.dr_value = item.tx_byte;
                            pos_next        = pos_inc;
                        end
                        if (pos_plus >= {1'b0, len_reg})
                        begin
                            phase_next = PH_BTF;
                        end
                    end
                    else if (sr[ST_BTF] && phase_reg == PH_BTF)
                    begin
                        if (rd_reg == RW_READ)
                        begin
                            if (len_two)
                            begin
                                result.rx_count    = 2'd2;
                                result.rx_byte_a   = item.rx_first;
                                result.rx_byte_b   = item.rx_second;
                                result.bus_command = BUS_STOP;
                                result.pos_control = POS_CLEAR;
                                result.done_res    = 1'b1;
                                pos_next           = LEN_BITS'(2);
                                phase_next         = PH_DONE;
                            end
                            else
                            begin
                                if (pos_in_range)
                                begin
                                    result.rx_count  = 2'd1;
                                    result.rx_byte_a = item.rx_first;
                                    result.rx_index  = 16'(pos_reg);
                                end
                                pos_next   = pos_inc;
                                phase_next = PH_DATA;
                            end
                        end
                        else
                        begin
                            result.bus_command = BUS_STOP;
                            result.done_res    = 1'b1;
                            phase_next         = PH_DONE;
                        end
                    end
                    else if (sr[ST_RXNE] && rd_reg == RW_READ && phase_reg == PH_DATA)
                    begin
                        if (pos_in_range)
                        begin
                            result.rx_count  = 2'd1;
                            result.rx_byte_a = item.rx_first;
                            result.rx_index  = 16'(pos_reg);
                        end
                        pos_next = pos_inc;
                        // The checks below look at the position after this byte.
                        if (len_one)
                        begin
                            result.done_res = 1'b1;
                            phase_next      = PH_DONE;
                        end
                        else if (len_big && pos_inc >= len_reg - LEN_BITS'(1))
                        begin
                            result.bus_command = BUS_STOP;
                            result.done_res    = 1'b1;
                            phase_next         = PH_DONE;
                        end
                        else if (len_big && pos_inc == len_reg - LEN_BITS'(2))
                        begin
                            result.ack_control = ACK_CLEAR;
                            phase_next         = PH_BTF;
                        end
                    end
                end
                FUNC_ERROR:
                begin
                    if (sr[ST_AF])
                    begin
                        result.bus_command = BUS_STOP;
                        result.done_res    = 1'b1;
                        result.failed      = 1'b1;
                        phase_next         = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            addr_reg  <= '0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            rd_reg    <= rd_next;
        end
    end
endmodule

[hdl/i2cms_out_reg.sv]
// Result register stage: holds one response beat until the consumer takes it.
module i2cms_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_valid,
    output logic            load_ready,
    input  i2cms_pkg::rsp_t load_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output i2cms_pkg::rsp_t rsp
);
    import i2cms_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign load_ready = !valid_reg || rsp_ready;
    assign valid_next = (load_valid && load_ready) ? 1'b1 :
                        (rsp_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;
endmodule

[hdl/i2c_master_transfer_sequencer.sv]
// Top level of the I2C master transfer sequencer.
// Each request passes through the input register and then the result register before it is a response.
// Throughput: one request beat per cycle while the consumer does not stall; each beat yields exactly one response beat.
// The rate is set by the combinational next-state logic between the input and result registers.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the
// transfer state to idle with position, length, address and direction cleared.
module i2c_master_transfer_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  i2cms_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output i2cms_pkg::rsp_t rsp
);
    import i2cms_pkg::*;

    // Request beat sitting in the input register.
    logic item_valid;
    req_t item;

    // The sequencer steps whenever a request is held and the result register can take
    // the response, so a stalled consumer backs up through both registers in turn.
    logic res_ready;
    logic fire;
    rsp_t result;

    assign fire = item_valid && res_ready;

    i2cms_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    // The transfer state only changes on a step, so each request is applied exactly once.
    i2cms_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    i2cms_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_ready (res_ready),
        .load_data  (result),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    // A failed transfer always ends with STOP and the done flag.
    a_fail_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.failed |-> rsp.done_res && rsp.bus_command == BUS_STOP)
        else $error("failed response without done and STOP");

    // Two bytes at once only come from the closing beat of a two-byte read.
    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.rx_count == 2'd2 |-> rsp.done_res && rsp.pos_control == POS_CLEAR)
        else $error("two-byte delivery outside the closing beat");

    // A beat never both writes the data register and delivers received bytes.
    a_no_mixed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.dr_write && rsp.rx_count != 2'd0))
        else $error("data register write mixed with received bytes");

    // An accepted request is held in the input register on the next cycle.
    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> item_valid)
        else $error("accepted request lost");
endmodule

[verif/tb_i2c_master_transfer_sequencer.sv]
// Testbench for the I2C master transfer sequencer: transfers in, checked response beats out.
module tb_i2c_master_transfer_sequencer;

    import i2cms_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 8;

    // The block ignores this function code; it is sent on purpose as noise.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Single-bit masks for the status snapshot.
    localparam logic [10:0] F_SB   = 11'(1) << ST_SB;
    localparam logic [10:0] F_ADDR = 11'(1) << ST_ADDR;
    localparam logic [10:0] F_BTF  = 11'(1) << ST_BTF;
    localparam logic [10:0] F_RXNE = 11'(1) << ST_RXNE;
    localparam logic [10:0] F_TXE  = 11'(1) << ST_TXE;
    localparam logic [10:0] F_AF   = 11'(1) << ST_AF;

    // The scoreboard keeps its own copy of the transfer state. Each accepted request
    // is run through it at once and the response it should cause goes into a queue;
    // each accepted response is matched against the oldest entry of that queue.
    class transfer_scoreboard;
        phase_t              cur_phase;
        logic [LEN_BITS-1:0] byte_pos;
        logic [LEN_BITS-1:0] held_len;
        logic [6:0]          held_addr;
        logic                dir_read;
        rsp_t                expected_q[$];
        int                  errors;
        int                  beat_no;

        function new();
            cur_phase = PH_IDLE;
            byte_pos  = '0;
            held_len  = '0;
            held_addr = '0;
            dir_read  = 1'b0;
            errors    = 0;
            beat_no   = 0;
        endfunction

        task report(string msg);
            $display("tb: response beat %0d: %s", beat_no, msg);
            errors++;
        endtask

        // A received byte is handed out only while the position is inside the length.
        function void take_byte(inout rsp_t o, input logic [7:0] b);
            if (byte_pos < held_len)
            begin
                o.rx_count  = 2'd1;
                o.rx_byte_a = b;
                o.rx_index  = byte_pos;
            end
            byte_pos = byte_pos + 1'b1;
        endfunction

        function void close_transfer(inout rsp_t o, input logic fail);
            o.done_res = 1'b1;
            o.failed   = fail;
            cur_phase  = PH_DONE;
        endfunction

        // Status event: the first rule whose flag and phase match wins.
        function void apply_status(inout rsp_t o, input req_t r);
            logic [10:0]         sr;
            logic [LEN_BITS-1:0] p;
            sr = r.status_flags;
            if (sr[ST_SB] && cur_phase == PH_SB)
            begin
                o.dr_write = 1'b1;
                o.dr_value = {held_addr, dir_read};
                cur_phase  = PH_ADDR;
            end
            else if (sr[ST_ADDR] && cur_phase == PH_ADDR)
            begin
                o.addr_clear = 1'b1;
                byte_pos     = '0;
                cur_phase    = PH_DATA;
                if (dir_read == RW_READ)
                begin
                    if (held_len == 0)
                    begin
                        o.bus_command = BUS_STOP;
                        close_transfer(o, 1'b0);
                    end
                    else if (held_len == 1)
                    begin
                        o.ack_control = ACK_CLEAR;
                        o.bus_command = BUS_STOP;
                    end
                    else if (held_len == 2)
                    begin
                        o.pos_control = POS_SET;
                        o.ack_control = ACK_CLEAR;
                        cur_phase     = PH_BTF;
                    end
                    else
                    begin
                        o.ack_control = ACK_SET;
                    end
                end
            end
            else if (sr[ST_TXE] && dir_read != RW_READ && cur_phase == PH_DATA)
            begin
                p = byte_pos;
                if (p < held_len)
                begin
                    o.dr_write = 1'b1;
                    o.dr_value = r.tx_byte;
                    byte_pos   = p + 1'b1;
                end
                if (p + 17'd1 >= held_len)
                    cur_phase = PH_BTF;
            end
            else if (sr[ST_BTF] && cur_phase == PH_BTF)
            begin
                if (dir_read == RW_READ)
                begin
                    if (held_len == 2)
                    begin
                        o.rx_count    = 2'd2;
                        o.rx_byte_a   = r.rx_first;
                        o.rx_byte_b   = r.rx_second;
                        o.rx_index    = '0;
                        o.bus_command = BUS_STOP;
                        o.pos_control = POS_CLEAR;
                        byte_pos      = LEN_BITS'(2);
                        close_transfer(o, 1'b0);
                    end
                    else
                    begin
                        take_byte(o, r.rx_first);
                        cur_phase = PH_DATA;
                    end
                end
                else
                begin
                    o.bus_command = BUS_STOP;
                    close_transfer(o, 1'b0);
                end
            end
            else if (sr[ST_RXNE] && dir_read == RW_READ && cur_phase == PH_DATA)
            begin
                take_byte(o, r.rx_first);
                if (held_len == 1)
                begin
                    close_transfer(o, 1'b0);
                end
                else if (held_len >= 3 && byte_pos >= held_len - 1'b1)
                begin
                    o.bus_command = BUS_STOP;
                    close_transfer(o, 1'b0);
                end
                else if (held_len >= 3 && byte_pos == held_len - 2'd2)
                begin
                    o.ack_control = ACK_CLEAR;
                    cur_phase     = PH_BTF;
                end
            end
        endfunction

        function void note_request(req_t r);
            rsp_t o;
            o = '0;
            case (r.func)
                FUNC_START:
                begin
                    held_addr     = r.target_addr;
                    dir_read      = r.is_read;
                    held_len      = r.byte_count;
                    byte_pos      = '0;
                    cur_phase     = PH_SB;
                    o.bus_command = BUS_START;
                end
                FUNC_EVENT:
                begin
                    apply_status(o, r);
                end
                FUNC_ERROR:
                begin
                    if (r.status_flags[ST_AF])
                    begin
                        o.bus_command = BUS_STOP;
                        close_transfer(o, 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(o);
        endfunction

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            beat_no++;
            if (expected_q.size() == 0)
            begin
                report("response with no request pending");
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("dr_write",    got.dr_write,    want.dr_write);
                compare_field("dr_value",    got.dr_value,    want.dr_value);
                compare_field("rx_count",    got.rx_count,    want.rx_count);
                compare_field("rx_byte_a",   got.rx_byte_a,   want.rx_byte_a);
                compare_field("rx_byte_b",   got.rx_byte_b,   want.rx_byte_b);
                compare_field("rx_index",    got.rx_index,    want.rx_index);
                compare_field("bus_command", got.bus_command, want.bus_command);
                compare_field("ack_control", got.ack_control, want.ack_control);
                compare_field("pos_control", got.pos_control, want.pos_control);
                compare_field("addr_clear",  got.addr_clear,  want.addr_clear);
                compare_field("done_res",    got.done_res,    want.done_res);
                compare_field("failed",      got.failed,      want.failed);
            end
        endtask
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    transfer_scoreboard sb = new();

    // Knobs shared by the sender and the receiver. While no_idle is set neither side
    // inserts gaps; hold_off_req asks the receiver for its one long hold-off, and
    // pressure_left keeps the sender offering back to back while that is going on.
    bit no_idle       = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_taken    = 1'b0;
    int pressure_left = 0;
    int items_sent    = 0;

    i2c_master_transfer_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Handshakes are sampled right after the edge. All drives are nonblocking, so the
    // values seen here are the ones that stood before the edge, when the beat moved.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    // Every field gets fresh random content; the caller then pins what matters.
    function automatic req_t random_req(logic [1:0] f, logic [10:0] flags);
        req_t r;
        r.func         = f;
        r.target_addr  = 7'($urandom);
        r.is_read      = 1'($urandom);
        r.byte_count   = 16'($urandom);
        r.status_flags = flags;
        r.tx_byte      = 8'($urandom);
        r.rx_first     = 8'($urandom);
        r.rx_second    = 8'($urandom);
        return r;
    endfunction

    function automatic req_t start_req(logic [6:0] addr, logic rd, logic [15:0] len);
        req_t r;
        r             = random_req(FUNC_START, 11'($urandom));
        r.target_addr = addr;
        r.is_read     = rd;
        r.byte_count  = len;
        return r;
    endfunction

    // A status snapshot carrying the wanted flag. Now and then other flags ride along;
    // they never take priority, since every rule also depends on the phase.
    function automatic req_t status_req(logic [10:0] flags);
        logic [10:0] extra;
        extra = ($urandom_range(0, 3) == 0) ? 11'($urandom) : '0;
        return random_req(FUNC_EVENT, flags | extra);
    endfunction

    // Called at a rising edge; returns when the beat is taken and any gap is done.
    // Valid drops only before a gap, so back-to-back beats keep it high throughout.
    task automatic send_item(req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        if (pressure_left > 0)
            pressure_left--;
        if (!no_idle && pressure_left == 0 && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_noise();
        logic [1:0] f;
        f = 2'($urandom_range(0, 3));
        send_item(random_req(f, 11'($urandom)));
    endtask

    // One transfer as the controller would report it. Now and then the sequence is cut
    // short, laced with noise, or ended by a no-acknowledge error.
    task automatic run_transfer();
        logic [10:0] steps[$];
        int          len;
        int          pick;
        int          cut;
        logic        rd;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            len = $urandom_range(0, 4);
        else if (pick < 85)
            len = $urandom_range(5, 12);
        else if (pick < 97)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(41, 200);
        rd = 1'($urandom);

        steps.push_back(F_SB);
        steps.push_back(F_ADDR);
        if (rd == RW_READ)
        begin
            if (len == 1)
            begin
                steps.push_back(F_RXNE);
            end
            else if (len == 2)
            begin
                steps.push_back(F_BTF);
            end
            else if (len >= 3)
            begin
                repeat (len - 2) steps.push_back(F_RXNE);
                steps.push_back(F_BTF);
                steps.push_back(F_RXNE);
            end
        end
        else
        begin
            // A write probe still needs one empty-buffer event to reach byte-done.
            repeat ((len == 0) ? 1 : len) steps.push_back(F_TXE);
            steps.push_back(F_BTF);
        end

        cut = steps.size();
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(0, steps.size());

        send_item(start_req(7'($urandom), rd, 16'(len)));
        items_sent++;
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_noise();
            send_item(status_req(steps[i]));
            items_sent++;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            send_item(random_req(FUNC_ERROR, F_AF | 11'($urandom)));
            items_sent++;
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request so the block
    // fills up and has to push back on the request side.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_i2c_master_transfer_sequencer: errors");
        $finish;
    end

    initial
    begin
        req_t r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An unused function code with every field at its top value,
        // then error events without and with the no-ack bit while idle.
        r      = '1;
        r.func = FUNC_UNUSED;
        send_item(r);
        send_item(random_req(FUNC_ERROR, ~F_AF));
        send_item(random_req(FUNC_ERROR, F_AF));

        // Write to the top address with the longest length, abandoned by a new start.
        send_item(start_req('1, 1'b0, '1));
        send_item(status_req(F_SB));
        send_item(status_req(F_ADDR));
        r         = status_req(F_TXE);
        r.tx_byte = '1;
        send_item(r);

        // Read of length zero from address zero: STOP right at the address phase.
        send_item(start_req('0, RW_READ, 16'd0));
        send_item(status_req(F_SB));
        send_item(status_req(F_ADDR));

        // Single-byte read.
        send_item(start_req(7'h55, RW_READ, 16'd1));
        send_item(status_req(F_SB));
        send_item(status_req(F_ADDR));
        r          = status_req(F_RXNE);
        r.rx_first = '1;
        send_item(r);

        // Two-byte read: both bytes come out together on byte-done.
        send_item(start_req(7'h2A, RW_READ, 16'd2));
        send_item(status_req(F_SB));
        send_item(status_req(F_ADDR));
        r           = status_req(F_BTF);
        r.rx_first  = 8'hA5;
        r.rx_second = 8'h5A;
        send_item(r);

        // Write probe with no data bytes.
        send_item(start_req(7'h3C, 1'b0, 16'd0));
        send_item(status_req(F_SB));
        send_item(status_req(F_ADDR));
        send_item(status_req(F_TXE));
        send_item(status_req(F_BTF));

        // Random part: mostly well-formed transfers, a little noise. Quiet stretches
        // come and go, and the tail of the run has no idling at all.
        while (items_sent < RANDOM_ITEMS)
        begin
            no_idle = (items_sent > RANDOM_ITEMS * 85 / 100) || ($urandom_range(0, 3) == 0);
            if (!hold_off_req && items_sent > 300)
            begin
                hold_off_req  = 1'b1;
                pressure_left = 60;
            end
            if ($urandom_range(0, 99) < 8)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                run_transfer();
        end
        req_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_i2c_master_transfer_sequencer: clean");
        else
            $display("tb_i2c_master_transfer_sequencer: errors");
        $finish;
    end

endmodule
